// ===== hdl/rau_pkg.sv =====
`timescale 1ns / 1ps
package rau_pkg;
	localparam int unsigned OPERAND_WIDTH_DEF = 32;
	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SUB = 2'd1;
	localparam logic [1:0] FUNC_MUL = 2'd2;
	localparam logic [1:0] FUNC_DIV = 2'd3;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_ZERO_DEN = 1'b1;
endpackage

// ===== hdl/rational_arith_unit.sv =====
`timescale 1ns / 1ps
// Sequence: three multiplies, then the sum is formed; unless the denominator is zero,
// one divider pass follows per Euclid step and two more for the reductions; busy stays
// high throughout.
// One transaction at a time. The result strobe lasts one cycle; the receiver
// cannot stall. Reset is asynchronous, active low, and returns the sequencer to idle.
module rational_arith_unit import rau_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [31:0] a_numerator,
	input  logic [31:0] a_denominator,
	input  logic [31:0] b_numerator,
	input  logic [31:0] b_denominator,
	output logic        strobe,
	output logic [31:0] res_numerator,
	output logic [31:0] res_denominator,
	output logic        status
);
	localparam int unsigned W = OPERAND_WIDTH;
	localparam int unsigned P = 2 * W;
	localparam int unsigned N = P + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_SUM, ST_GCD, ST_RN, ST_RD, ST_OUT
	} state_t;
	state_t state_q;

	logic [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic an_s, ad_s, bn_s, bd_s;
	logic [1:0] func_q;
	logic [P-1:0] p0_q, p1_q;
	logic [N-1:0] nm_q, dm_q, ga_q, gb_q, gq_q;
	logic num_neg_q;
	logic [P-1:0] den_q;

	logic mgo, mdone;
	logic [W-1:0] mx, my;
	logic [P-1:0] mp;
	logic dgo, ddone;
	logic [N-1:0] dvd, dvs, dq, dr;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	rau_mul #(.W(W)) u_mul (.clk, .arst_n, .go(mgo), .x(mx), .y(my), .done(mdone), .p(mp));
	rau_div #(.N(N)) u_div (.clk, .arst_n, .go(dgo), .dividend(dvd), .divisor(dvs),
		.done(ddone), .quot(dq), .rem(dr));

	// pick multiplier operands by the state that issues the multiply
	always_comb begin
		mx = mag_of(an_q);
		my = mag_of(bd_q);
		case (state_q)
			ST_M1: begin
				mx = mag_of(bn_q); my = mag_of(ad_q);
			end
			ST_M2: begin
				mx = mag_of(ad_q);
				my = (func_q == FUNC_DIV) ? mag_of(bn_q) : mag_of(bd_q);
			end
			default: begin
				mx = mag_of(an_q);
				my = (func_q == FUNC_MUL) ? mag_of(bn_q) : mag_of(bd_q);
			end
		endcase
	end

	always_comb begin
		dvd = (state_q == ST_GCD) ? ga_q : (state_q == ST_RN ? nm_q : dm_q);
		dvs = (state_q == ST_GCD) ? gb_q : gq_q;
	end

	assign busy = (state_q != ST_IDLE);
	// kick the first multiply, then the next one after each of the first two finishes
	assign mgo  = (state_q == ST_M0) || ((state_q == ST_M1 || state_q == ST_M2) && mdone);

	logic [N-1:0] sa, sb, sum_mag;
	logic sa_neg, sb_neg, sum_neg;
	logic m1_neg, m2_neg;
	always_comb begin
		// sign of first and second product (second negated for subtraction)
		m1_neg = an_s ^ ((func_q == FUNC_MUL) ? bn_s : bd_s);
		m2_neg = bn_s ^ ad_s ^ (func_q == FUNC_SUB);
		sa = {1'b0, p0_q};
		sb = {1'b0, p1_q};
		sa_neg = m1_neg && (p0_q != '0);
		sb_neg = m2_neg && (p1_q != '0);
		if (func_q == FUNC_MUL || func_q == FUNC_DIV) begin
			sum_mag = sa; sum_neg = sa_neg;
		end else if (sa_neg == sb_neg) begin
			sum_mag = sa + sb; sum_neg = sa_neg;
		end else if (sa >= sb) begin
			sum_mag = sa - sb; sum_neg = sa_neg;
		end else begin
			sum_mag = sb - sa; sum_neg = sb_neg;
		end
	end

	logic den_neg;
	assign den_neg = ad_s ^ ((func_q == FUNC_DIV) ? bn_s : bd_s);
	logic [W-1:0] rn;
	assign rn = (num_neg_q != den_neg) ? (~dq[W-1:0] + 1'b1) : dq[W-1:0];

	// sequence multiplies, gcd and reduction; hold outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			strobe          <= 1'b0;
			dgo             <= 1'b0;
			p0_q            <= '0;
			p1_q            <= '0;
			den_q           <= '0;
			nm_q            <= '0;
			dm_q            <= '0;
			ga_q            <= '0;
			gb_q            <= '0;
			gq_q            <= '0;
			num_neg_q       <= 1'b0;
			res_numerator   <= '0;
			res_denominator <= '0;
			status          <= STATUS_OK;
		end else begin
			strobe <= 1'b0;
			dgo    <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_M0;
				ST_M0: state_q <= ST_M1;
				ST_M1: if (mdone) begin
					p0_q <= mp; state_q <= ST_M2;
				end
				ST_M2: if (mdone) begin
					p1_q <= mp; state_q <= ST_M3;
				end
				ST_M3: if (mdone) begin
					den_q <= mp; state_q <= ST_SUM;
				end
				ST_SUM: begin
					nm_q <= sum_mag; num_neg_q <= sum_neg;
					dm_q <= {1'b0, den_q};
					ga_q <= sum_mag; gb_q <= {1'b0, den_q};
					if (den_q == '0) begin
						res_numerator <= '0; res_denominator <= '0;
						status <= STATUS_ZERO_DEN; strobe <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						dgo <= 1'b1; state_q <= ST_GCD;
					end
				end
				ST_GCD: if (ddone) begin
					if (dr == '0) begin
						gq_q <= gb_q; dgo <= 1'b1; state_q <= ST_RN;
					end else begin
						ga_q <= gb_q; gb_q <= dr; dgo <= 1'b1;
					end
				end
				ST_RN: if (ddone) begin
					res_numerator <= 32'(rn);
					dgo <= 1'b1; state_q <= ST_RD;
				end
				ST_RD: if (ddone) begin
					res_denominator <= 32'(dq[W-1:0]);
					status <= STATUS_OK; strobe <= 1'b1; state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture operands at start (the first step uses them in the following cycle)
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_q <= func;
			an_q <= a_numerator[W-1:0]; ad_q <= a_denominator[W-1:0];
			bn_q <= b_numerator[W-1:0]; bd_q <= b_denominator[W-1:0];
		end
	end
	assign an_s = an_q[W-1];
	assign ad_s = ad_q[W-1];
	assign bn_s = bn_q[W-1];
	assign bd_s = bd_q[W-1];
endmodule

// ===== hdl/rau_mul.sv =====
`timescale 1ns / 1ps
// Bit-serial unsigned multiplier: one multiplier bit per cycle, shift-add.
module rau_mul import rau_pkg::*; #(
	parameter int unsigned W = OPERAND_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [W-1:0]     x,
	input  logic [W-1:0]     y,
	output logic             done,
	output logic [2*W-1:0]   p
);
	localparam int unsigned CW = $clog2(W + 1);
	logic [2*W-1:0] acc_q;
	logic [W-1:0]   yq_q;
	logic [W-1:0]   x_q;
	logic [CW-1:0]  cnt_q;
	logic           run_q;
	logic [W:0]     sum;

	// add multiplicand into the upper half, then shift right one bit
	assign sum = {1'b0, acc_q[2*W-1:W]} + (yq_q[0] ? {1'b0, x_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			x_q   <= x;
			yq_q  <= y;
		end else if (run_q) begin
			acc_q <= {sum, acc_q[W-1:1]};
			yq_q  <= yq_q >> 1;
		end
	end
	assign p = acc_q;
endmodule

// ===== hdl/rau_div.sv =====
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle.
module rau_div import rau_pkg::*; #(
	parameter int unsigned N = 2 * OPERAND_WIDTH_DEF + 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [N-1:0] dividend,
	input  logic [N-1:0] divisor,
	output logic         done,
	output logic [N-1:0] quot,
	output logic [N-1:0] rem
);
	localparam int unsigned CW = $clog2(N + 1);
	logic [N-1:0]  q_q;
	logic [N-1:0]  r_q;
	logic [N-1:0]  d_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [N:0]    trial;
	logic [N:0]    diff;

	assign trial = {r_q, q_q[N-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(N);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// shift in the next dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (run_q) begin
			if (!diff[N]) begin
				r_q <= diff[N-1:0];
				q_q <= {q_q[N-2:0], 1'b1};
			end else begin
				r_q <= trial[N-1:0];
				q_q <= {q_q[N-2:0], 1'b0};
			end
		end
	end
	assign quot = q_q;
	assign rem  = r_q;
endmodule

// ===== hdl/rau_checker.sv =====
`timescale 1ns / 1ps
module rau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic [31:0] res_numerator,
	input logic [31:0] res_denominator,
	input logic        status
);
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status |-> res_numerator == '0 && res_denominator == '0)
		else $error("error result not zero");
	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("strobe longer than one cycle");
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy) else $error("strobe while busy");
endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import rau_pkg::*;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] an;
		logic [31:0] ad;
		logic [31:0] bn;
		logic [31:0] bd;
	} frac_req_t;

	typedef struct packed {
		logic [31:0] num;
		logic [31:0] den;
		logic        stat;
	} frac_res_t;

	typedef struct packed {
		logic        neg;
		logic [63:0] mag;
	} signmag_t;

	localparam int unsigned N_ITEMS = 450;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [31:0] a_numerator;
	logic [31:0] a_denominator;
	logic [31:0] b_numerator;
	logic [31:0] b_denominator;
	logic        strobe;
	logic [31:0] res_numerator;
	logic [31:0] res_denominator;
	logic        status;

	frac_req_t   pending_q[$];
	frac_res_t   reduced_q[$];
	int unsigned gap_pct;
	int unsigned mismatches;
	int unsigned sent;
	int unsigned received;
	logic        took;
	frac_req_t   nxt;
	frac_req_t   seen;
	frac_res_t   got;
	frac_res_t   want;

	rational_arith_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.a_numerator(a_numerator),
		.a_denominator(a_denominator),
		.b_numerator(b_numerator),
		.b_denominator(b_denominator),
		.strobe(strobe),
		.res_numerator(res_numerator),
		.res_denominator(res_denominator),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// split a 32-bit operand into sign and magnitude
	function automatic signmag_t split_sm(logic [31:0] v);
		signmag_t r;
		logic [31:0] m;
		m = v[31] ? (~v + 32'd1) : v;
		r.neg = v[31];
		r.mag = {32'b0, m};
		return r;
	endfunction

	function automatic signmag_t sm_product(signmag_t x, signmag_t y);
		signmag_t r;
		r.mag = x.mag * y.mag;
		r.neg = (r.mag != 0) && (x.neg != y.neg);
		return r;
	endfunction

	function automatic signmag_t sm_sum(signmag_t x, signmag_t y);
		signmag_t r;
		if (x.neg == y.neg) begin
			r.neg = x.neg;
			r.mag = x.mag + y.mag;
		end else if (x.mag >= y.mag) begin
			r.neg = x.neg;
			r.mag = x.mag - y.mag;
		end else begin
			r.neg = y.neg;
			r.mag = y.mag - x.mag;
		end
		if (r.mag == 0)
			r.neg = 1'b0;
		return r;
	endfunction

	// exact fraction arithmetic, reduced by the gcd, wrapped to 32 bits
	function automatic frac_res_t reduce_fraction(frac_req_t q);
		frac_res_t r;
		signmag_t an, ad, bn, bd, num, den, t;
		logic [63:0] x, y, rem, nm, dm;
		an = split_sm(q.an);
		ad = split_sm(q.ad);
		bn = split_sm(q.bn);
		bd = split_sm(q.bd);
		case (q.op)
			FUNC_ADD: begin
				num = sm_sum(sm_product(an, bd), sm_product(bn, ad));
				den = sm_product(ad, bd);
			end
			FUNC_SUB: begin
				t = sm_product(bn, ad);
				if (t.mag != 0)
					t.neg = ~t.neg;
				num = sm_sum(sm_product(an, bd), t);
				den = sm_product(ad, bd);
			end
			FUNC_MUL: begin
				num = sm_product(an, bn);
				den = sm_product(ad, bd);
			end
			default: begin
				num = sm_product(an, bd);
				den = sm_product(ad, bn);
			end
		endcase
		if (den.mag == 0) begin
			r.num = '0;
			r.den = '0;
			r.stat = STATUS_ZERO_DEN;
			return r;
		end
		x = num.mag;
		y = den.mag;
		while (y != 0) begin
			rem = x % y;
			x = y;
			y = rem;
		end
		nm = num.mag / x;
		dm = den.mag / x;
		r.num = (num.neg != den.neg) ? (32'd0 - nm[31:0]) : nm[31:0];
		r.den = dm[31:0];
		r.stat = STATUS_OK;
		return r;
	endfunction

	// mix corner operands with random ones
	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		int unsigned k;
		k = $urandom_range(0, 9);
		case (k)
			0: v = 32'h0000_0000;
			1: v = 32'h0000_0001;
			2: v = 32'hFFFF_FFFF;
			3: v = 32'h8000_0000;
			4: v = 32'h7FFF_FFFF;
			5: v = 32'($urandom_range(0, 40)) - 32'd20;
			6: v = 32'($urandom_range(0, 2000)) - 32'd1000;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// drive the next transaction at the falling edge, hold it until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took) begin
			if (sent < N_ITEMS / 4)
				gap_pct = 0;
			else if (sent < N_ITEMS / 2)
				gap_pct = 64;
			else if (sent < 3 * N_ITEMS / 4)
				gap_pct = 0;
			else
				gap_pct = 10;
			if (pending_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				nxt = pending_q.pop_front();
				func          <= nxt.op;
				a_numerator   <= nxt.an;
				a_denominator <= nxt.ad;
				b_numerator   <= nxt.bn;
				b_denominator <= nxt.bd;
				start         <= 1'b1;
				sent++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// sample accepted transactions and results at the rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= start && !busy;
			if (strobe) begin
				got = {res_numerator, res_denominator, status};
				received++;
				if (reduced_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: num=%h den=%h status=%b",
							res_numerator, res_denominator, status);
				end else begin
					want = reduced_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected num=%h den=%h status=%b, got num=%h den=%h status=%b",
								want.num, want.den, want.stat,
								got.num, got.den, got.stat);
					end
				end
			end
			if (start && !busy) begin
				seen = {func, a_numerator, a_denominator, b_numerator, b_denominator};
				reduced_q.push_back(reduce_fraction(seen));
			end
		end
	end

	initial begin
		frac_req_t req;
		mismatches = 0;
		sent = 0;
		received = 0;
		gap_pct = 0;
		arst_n = 1'b0;
		for (int i = 0; i < N_ITEMS; i++) begin
			req.op = 2'($urandom_range(0, 3));
			req.an = pick_operand();
			req.ad = pick_operand();
			req.bn = pick_operand();
			req.bd = pick_operand();
			pending_q.push_back(req);
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (received == N_ITEMS);
		repeat (2) @(posedge clk);
		if (mismatches == 0 && reduced_q.size() == 0 && received == N_ITEMS)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("Verification failed");
		$finish;
	end
endmodule
